/* hw/rtl/fpic_pkg.sv */
// ----------------------------------------------------------------------------
// fpic_pkg
// Types and constants shared by the interrupt controller modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fpic_pkg;

   localparam int FLAG_WIDTH = 8;
   localparam int IDX_WIDTH  = 3;

   localparam logic [2:0] OP_READ    = 3'd0;
   localparam logic [2:0] OP_WRITE   = 3'd1;
   localparam logic [2:0] OP_REQUEST = 3'd2;
   localparam logic [2:0] OP_SET_ME  = 3'd3;
   localparam logic [2:0] OP_SERVICE = 3'd4;

   localparam logic [15:0] ADDR_FLAGS   = 16'h000F;
   localparam logic [15:0] ADDR_ENABLES = 16'h00FF;

   localparam logic [6:0] VECTOR_BASE = 7'h40;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] address;
      logic [7:0]  write_data;
      logic [4:0]  request_mask;
      logic        enable_value;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
      logic       vector_valid;
      logic [6:0] vector_address;
      logic       pending;
      logic       master_enable;
   } rsp_payload_type;

   typedef struct packed {
      logic                 found;
      logic [IDX_WIDTH-1:0] index;
   } prio_type;

endpackage

`default_nettype wire

/* hw/rtl/fpic_stream_if.sv */
// ----------------------------------------------------------------------------
// fpic_stream_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fpic_stream_if #(
   parameter type payload_type = logic
) ();

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

/* hw/rtl/fpic_prio_enc.sv */
// ----------------------------------------------------------------------------
// fpic_prio_enc
// Fixed-priority encoder: lowest set bit among the implemented sources wins.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpic_prio_enc
   import fpic_pkg::*;
#(
   parameter int NUM_SOURCES = 5
) (
   input  wire logic [FLAG_WIDTH-1:0] eligible,
   output prio_type                   prio
);

   logic [FLAG_WIDTH-1:0] source_mask;

   always_comb begin
      for (int i = 0; i < FLAG_WIDTH; i++) begin
         source_mask[i] = (i < NUM_SOURCES);
      end
   end

   // scan high to low so the lowest eligible source is the last to land
   always_comb begin
      prio.found = 1'b0;
      prio.index = '0;
      for (int i = FLAG_WIDTH - 1; i >= 0; i--) begin
         if (eligible[i] && source_mask[i]) begin
            prio.found = 1'b1;
            prio.index = IDX_WIDTH'(i);
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/fpic_engine.sv */
// ----------------------------------------------------------------------------
// fpic_engine
// Flag, enable and master enable registers with the per-operation logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fpic_engine
   import fpic_pkg::*;
#(
   parameter int NUM_SOURCES = 5
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      step,
   input  req_payload_type item,
   output rsp_payload_type result
);

   logic [FLAG_WIDTH-1:0] flags_ff, flags_in;
   logic [FLAG_WIDTH-1:0] enables_ff, enables_in;
   logic                  me_ff, me_in;
   prio_type              prio;

   fpic_prio_enc #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_prio_enc (
      .eligible (flags_ff & enables_ff),
      .prio     (prio)
   );

   always_comb begin
      flags_in              = flags_ff;
      enables_in            = enables_ff;
      me_in                 = me_ff;
      result.read_data      = '0;
      result.status         = 1'b0;
      result.vector_valid   = 1'b0;
      result.vector_address = '0;

      unique case (item.operation)
         OP_READ: begin
            if (item.address == ADDR_FLAGS) begin
               result.read_data = flags_ff;
            end else if (item.address == ADDR_ENABLES) begin
               result.read_data = enables_ff;
            end else begin
               result.status = 1'b1;
            end
         end
         OP_WRITE: begin
            if (item.address == ADDR_FLAGS) begin
               flags_in = item.write_data;
            end else if (item.address == ADDR_ENABLES) begin
               enables_in = item.write_data;
            end else begin
               result.status = 1'b1;
            end
         end
         OP_REQUEST: begin
            flags_in = flags_ff | FLAG_WIDTH'(item.request_mask);
         end
         OP_SET_ME: begin
            me_in = item.enable_value;
         end
         OP_SERVICE: begin
            if (prio.found) begin
               flags_in              = flags_ff & ~(FLAG_WIDTH'(1) << prio.index);
               me_in                 = 1'b0;
               result.vector_valid   = 1'b1;
               result.vector_address = VECTOR_BASE + 7'({prio.index, 3'b000});
            end
         end
         default: begin
         end
      endcase

      result.pending       = (flags_in != '0);
      result.master_enable = me_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         enables_ff <= '0;
         me_ff      <= 1'b0;
      end else if (step) begin
         flags_ff   <= flags_in;
         enables_ff <= enables_in;
         me_ff      <= me_in;
      end
   end

   a_vector_clears_me: assert property (@(posedge clock) disable iff (reset)
      result.vector_valid |-> !result.master_enable && !result.status)
      else $error("serviced vector without master enable cleared");

   a_service_drops_flag: assert property (@(posedge clock) disable iff (reset)
      step && result.vector_valid |=> !flags_ff[$past(prio.index)] && !me_ff)
      else $error("serviced source flag still set");

   a_status_bus_only: assert property (@(posedge clock) disable iff (reset)
      result.status |-> (item.operation == OP_READ || item.operation == OP_WRITE))
      else $error("bad address status outside a bus access");

endmodule

`default_nettype wire

/* hw/rtl/fixed_priority_interrupt_controller_top.sv */
// ----------------------------------------------------------------------------
// fixed_priority_interrupt_controller_top
// Five-source vectored interrupt controller. Each request transfer is one
// operation (bus read/write of flags at 0x000F or enables at 0x00FF, source
// request, master enable write, or service) and yields exactly one response.
// One operation is accepted per cycle while rsp.ready keeps responses moving;
// each is held in the input register until it advances, and its response is
// then captured in the result register and presented from there. The register
// update and priority encode are done in one combinational pass between them.
// Operations see the state left by the previous one, so results match strict
// program order under any stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fixed_priority_interrupt_controller_top
   import fpic_pkg::*;
#(
   parameter int NUM_SOURCES = 5
) (
   input  wire logic      clock,
   input  wire logic      reset,
   fpic_stream_if.sink    req,
   fpic_stream_if.source  rsp
);

   logic            in_valid_ff;
   req_payload_type item_ff;
   logic            out_valid_ff;
   rsp_payload_type rsp_ff;
   rsp_payload_type result;
   logic            advance;
   logic            req_fire;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   fpic_engine #(
      .NUM_SOURCES (NUM_SOURCES)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff <= req.payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp.valid   = out_valid_ff;
   assign rsp.payload = rsp_ff;

   a_held_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(item_ff))
      else $error("stalled operation lost from input stage");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("response dropped after advance");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.payload))
      else $error("stalled response changed");

endmodule

`default_nettype wire
